// ----- rtl/upw_pkg.sv -----
// upw_pkg: shared constants, types and register codes for the upwind advection stencil
// no dependencies; used by the channel interfaces, the divider and the top level
package upw_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int VAL_W     = 32;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = 16;
  localparam int GW_W      = COL_W + 1;
  localparam int FRAC_W    = 16;
  localparam int DIV_W     = VAL_W + FRAC_W;
  localparam int NVEL      = 6;
  localparam int NOPS      = 6;
  localparam int NQ        = 4;
  localparam int WIDE_W    = 64;
  localparam int PROD_W    = VAL_W + DIV_W;

  localparam logic [GW_W-1:0]  WIDTH_RESET  = GW_W'(1024);
  localparam logic [ROW_W-1:0] HEIGHT_RESET = ROW_W'(1024);

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [NQ-1:0][VAL_W-1:0] cell_t;

  typedef enum logic [1:0] {
    REG_GRID_WIDTH,
    REG_GRID_HEIGHT,
    REG_DT_DX,
    REG_DT_DY
  } reg_idx_t;

  typedef struct packed {
    logic start;
    val_t num;
    val_t den;
  } div_req_t;

  typedef struct packed {
    logic done;
    val_t quot;
  } div_rsp_t;

endpackage

// ----- rtl/upw_if.sv -----
// upw_in_if / upw_out_if: valid-ready channels for grid cells and cell updates
// depends on upw_pkg
interface upw_in_if;
  import upw_pkg::*;
  logic valid;
  logic ready;
  val_t density;
  val_t momentum_x;
  val_t momentum_y;
  val_t energy;
  modport source (output valid, density, momentum_x, momentum_y, energy, input ready);
  modport sink   (input valid, density, momentum_x, momentum_y, energy, output ready);
endinterface

interface upw_out_if;
  import upw_pkg::*;
  logic             valid;
  logic             ready;
  val_t             new_density;
  val_t             new_momentum_x;
  val_t             new_momentum_y;
  val_t             new_energy;
  logic [COL_W-1:0] cell_column;
  logic [ROW_W-1:0] cell_row;
  logic             last_cell;
  modport source (output valid, new_density, new_momentum_x, new_momentum_y, new_energy,
                  cell_column, cell_row, last_cell, input ready);
  modport sink   (input valid, new_density, new_momentum_x, new_momentum_y, new_energy,
                  cell_column, cell_row, last_cell, output ready);
endinterface

// ----- rtl/upw_div.sv -----
// upw_div: radix-2 restoring divider for Q16.16 velocity, one quotient bit a cycle
// depends on upw_pkg
module upw_div (
  input  logic             clk,
  input  logic             rst_n,
  input  upw_pkg::div_req_t req,
  output upw_pkg::div_rsp_t rsp
);
  import upw_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} st_t;

  localparam int CNT_W = $clog2(DIV_W);

  st_t              st_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0] acc_r;
  logic [VAL_W:0]   rem_r;
  logic [VAL_W-1:0] dv_r;
  logic             neg_r;
  logic             zero_r;

  logic [VAL_W-1:0] num_mag;
  logic [VAL_W-1:0] den_mag;
  logic [VAL_W:0]   shifted;
  logic             fits;
  val_t             quot;

  // operand magnitudes and one trial subtraction
  always_comb begin
    num_mag = req.num[VAL_W-1] ? VAL_W'(~req.num + 1'b1) : VAL_W'(req.num);
    den_mag = req.den[VAL_W-1] ? VAL_W'(~req.den + 1'b1) : VAL_W'(req.den);
    shifted = {rem_r[VAL_W-1:0], acc_r[DIV_W-1]};
    fits    = shifted >= {1'b0, dv_r};
  end

  // sign and saturation of the quotient
  always_comb begin
    if (zero_r) begin
      quot = '0;
    end else if (neg_r) begin
      if (acc_r > DIV_W'(64'h8000_0000)) quot = val_t'(32'h8000_0000);
      else quot = val_t'(~acc_r[VAL_W-1:0] + 1'b1);
    end else begin
      if (acc_r > DIV_W'(64'h7FFF_FFFF)) quot = val_t'(32'h7FFF_FFFF);
      else quot = val_t'(acc_r[VAL_W-1:0]);
    end
    rsp.done = (st_r == S_DONE);
    rsp.quot = quot;
  end

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      cnt_r <= '0;
    end else begin
      unique case (st_r)
        S_IDLE: begin
          if (req.start) begin
            acc_r  <= {num_mag, FRAC_W'(0)};
            rem_r  <= '0;
            dv_r   <= den_mag;
            neg_r  <= req.num[VAL_W-1] ^ req.den[VAL_W-1];
            zero_r <= (req.den == '0);
            cnt_r  <= '0;
            st_r   <= (req.den == '0) ? S_DONE : S_RUN;
          end
        end
        S_RUN: begin
          rem_r <= fits ? (shifted - {1'b0, dv_r}) : shifted;
          acc_r <= {acc_r[DIV_W-2:0], fits};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(DIV_W - 1)) st_r <= S_DONE;
        end
        S_DONE: begin
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/upwind_advection_stencil_2d.sv -----
// upwind_advection_stencil_2d: raster-order 2D upwind advection with two row stores
// interior cell: six divisions through one divider (a zero-density division skips the bit loop),
// then 24 products, each from two shared 32x32 multiplies; border cells only shift the rows and
// give no result; one cell at a time
// reset: synchronous, active low; counters, geometry and control clear, row stores do not
// depends on upw_pkg, upw_if.sv and upw_div
module upwind_advection_stencil_2d (
  input  logic                    clk,
  input  logic                    rst_n,
  upw_in_if.sink                  in_ch,
  upw_out_if.source               out_ch,
  input  logic                    cfg_wr_en,
  input  upw_pkg::reg_idx_t       cfg_index,
  input  logic [upw_pkg::VAL_W-1:0] cfg_wdata
);
  import upw_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_DIV_GO, S_DIV, S_FACE, S_SEL, S_MLO, S_MHI, S_ACC, S_FIN,
    S_DIFF, S_UPD, S_DONE
  } st_t;

  typedef logic signed [WIDE_W-1:0] wide_t;

  localparam int VI_W = $clog2(NVEL);
  localparam int OP_W = $clog2(NOPS);
  localparam int K_W  = $clog2(NQ);
  localparam int BX_W = DIV_W;

  // configuration
  logic [GW_W-1:0]  gw_r;
  logic [ROW_W-1:0] gh_r;
  logic [VAL_W-1:0] dtx_r;
  logic [VAL_W-1:0] dty_r;

  // position and control
  st_t              st_r;
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic [COL_W-1:0] c_q_r;
  logic [ROW_W-1:0] r_q_r;
  logic             interior_r;
  logic             last_r;
  logic [VI_W-1:0]  vidx_r;
  logic [OP_W-1:0]  op_r;
  logic [K_W-1:0]   k_r;

  // row stores and neighbourhood
  cell_t mid_mem [MAX_WIDTH];
  cell_t low_mem [MAX_WIDTH];
  cell_t mid_c_q, mid_r_q, low_c_q;
  cell_t left_r, cur_r, ctr_r, rgt_r, bot_r, lft_r;

  // arithmetic
  val_t              vel_r  [NVEL];
  val_t              face_r [NQ];
  wide_t             prod_r [NOPS];
  wide_t             dx_r, dy_r;
  logic [VAL_W-1:0]  a_r;
  logic [BX_W-1:0]   b_r;
  logic              neg_r;
  logic [WIDE_W-1:0] p_r;
  logic [PROD_W-1:0] acc_r;
  val_t              nv_r [NQ];

  // output register
  logic             out_vld_r;
  val_t             o_den_r, o_mx_r, o_my_r, o_en_r;
  logic [COL_W-1:0] o_col_r;
  logic [ROW_W-1:0] o_row_r;
  logic             o_last_r;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic             in_acc;
  logic [GW_W-1:0]  wc;
  logic [ROW_W-1:0] hc;
  logic [GW_W-1:0]  col_p1;
  logic [ROW_W:0]   row_p1;
  logic [COL_W-1:0] col_nx;
  logic             interior;
  logic             last_now;
  logic [VAL_W-1:0] sel_a;
  logic [BX_W-1:0]  sel_b;
  logic             sel_neg;
  val_t             sel_u;
  logic [VAL_W-1:0] sel_q;
  logic [WIDE_W-1:0] m_prod;
  wide_t            fin_res;
  logic signed [WIDE_W+1:0] upd_sum;
  val_t             upd_val;
  logic             out_free;

  function automatic logic [VAL_W-1:0] mag32(input logic [VAL_W-1:0] v);
    return v[VAL_W-1] ? VAL_W'(~v + 1'b1) : v;
  endfunction

  function automatic logic [WIDE_W-1:0] mag64(input logic [WIDE_W-1:0] v);
    return v[WIDE_W-1] ? WIDE_W'(~v + 1'b1) : v;
  endfunction

  // face velocity: half the sum, truncated toward zero
  function automatic val_t half_sum(input val_t a, input val_t b);
    logic signed [VAL_W:0] s;
    logic signed [VAL_W:0] t;
    s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
    t = s + (VAL_W+1)'(s[VAL_W]);
    return val_t'(t[VAL_W:1]);
  endfunction

  // clamped geometry and counter arithmetic
  always_comb begin
    in_acc   = in_ch.valid && in_ch.ready;
    wc       = (gw_r < GW_W'(3)) ? GW_W'(3) :
               (gw_r > GW_W'(MAX_WIDTH)) ? GW_W'(MAX_WIDTH) : gw_r;
    hc       = (gh_r < ROW_W'(3)) ? ROW_W'(3) : gh_r;
    col_p1   = {1'b0, col_r} + 1'b1;
    row_p1   = {1'b0, row_r} + 1'b1;
    col_nx   = col_p1[COL_W-1:0];
    interior = (row_r >= ROW_W'(2)) && (row_r < hc) && (col_r != '0) && (col_p1 < wc);
    last_now = ({1'b0, col_r} == (wc - GW_W'(2))) && (row_r == (hc - 1'b1));
  end

  // divider operands for the six velocities
  always_comb begin
    div_req.start = (st_r == S_DIV_GO);
    unique case (vidx_r)
      VI_W'(0): begin div_req.num = val_t'(ctr_r[1]); div_req.den = val_t'(ctr_r[0]); end
      VI_W'(1): begin div_req.num = val_t'(ctr_r[2]); div_req.den = val_t'(ctr_r[0]); end
      VI_W'(2): begin div_req.num = val_t'(lft_r[1]); div_req.den = val_t'(lft_r[0]); end
      VI_W'(3): begin div_req.num = val_t'(rgt_r[1]); div_req.den = val_t'(rgt_r[0]); end
      VI_W'(4): begin div_req.num = val_t'(bot_r[2]); div_req.den = val_t'(bot_r[0]); end
      VI_W'(5): begin div_req.num = val_t'(cur_r[2]); div_req.den = val_t'(cur_r[0]); end
      default:  begin div_req.num = '0;               div_req.den = '0;               end
    endcase
  end

  upw_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // multiplier operand selection: upwind fluxes, then the dt scaling
  always_comb begin
    sel_u = face_r[0];
    sel_q = ctr_r[k_r];
    sel_a = '0;
    sel_b = '0;
    sel_neg = 1'b0;
    unique case (op_r)
      OP_W'(0): begin
        sel_u = face_r[0];
        sel_q = (face_r[0] > 0) ? lft_r[k_r] : ctr_r[k_r];
      end
      OP_W'(1): begin
        sel_u = face_r[1];
        sel_q = (face_r[1] < 0) ? rgt_r[k_r] : ctr_r[k_r];
      end
      OP_W'(2): begin
        sel_u = face_r[2];
        sel_q = (face_r[2] > 0) ? bot_r[k_r] : ctr_r[k_r];
      end
      OP_W'(3): begin
        sel_u = face_r[3];
        sel_q = (face_r[3] < 0) ? cur_r[k_r] : ctr_r[k_r];
      end
      default: ;
    endcase
    unique case (op_r)
      OP_W'(4): begin
        sel_a   = dtx_r;
        sel_b   = BX_W'(mag64(dx_r));
        sel_neg = dx_r[WIDE_W-1];
      end
      OP_W'(5): begin
        sel_a   = dty_r;
        sel_b   = BX_W'(mag64(dy_r));
        sel_neg = dy_r[WIDE_W-1];
      end
      default: begin
        sel_a   = mag32(sel_u);
        sel_b   = {(BX_W-VAL_W)'(0), mag32(sel_q)};
        sel_neg = sel_u[VAL_W-1] ^ sel_q[VAL_W-1];
      end
    endcase
  end

  // product scaling, sign and 64-bit saturation; final update clamp
  always_comb begin
    m_prod = acc_r[PROD_W-1:FRAC_W];
    if (neg_r) fin_res = m_prod[WIDE_W-1] ? wide_t'({1'b1, (WIDE_W-1)'(0)})
                                          : wide_t'(~m_prod + 1'b1);
    else       fin_res = m_prod[WIDE_W-1] ? wide_t'({1'b0, {(WIDE_W-1){1'b1}}})
                                          : wide_t'(m_prod);
    upd_sum = (WIDE_W+2)'(val_t'(ctr_r[k_r])) - (WIDE_W+2)'(prod_r[4])
              - (WIDE_W+2)'(prod_r[5]);
    if (upd_sum[WIDE_W+1:VAL_W-1] == '0 || (&upd_sum[WIDE_W+1:VAL_W-1]))
      upd_val = val_t'(upd_sum[VAL_W-1:0]);
    else if (upd_sum[WIDE_W+1])
      upd_val = val_t'({1'b1, (VAL_W-1)'(0)});
    else
      upd_val = val_t'({1'b0, {(VAL_W-1){1'b1}}});
    out_free = !out_vld_r || out_ch.ready;
  end

  // row stores: read on the input beat, shift rows down in the next cycle (S_LOAD)
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mid_c_q <= mid_mem[col_r];
      mid_r_q <= mid_mem[col_nx];
      low_c_q <= low_mem[col_r];
    end
    if (st_r == S_LOAD) begin
      low_mem[c_q_r] <= mid_c_q;
      mid_mem[c_q_r] <= cur_r;
    end
  end

  // sequencer, configuration and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      gw_r      <= WIDTH_RESET;
      gh_r      <= HEIGHT_RESET;
      dtx_r     <= '0;
      dty_r     <= '0;
      col_r     <= '0;
      row_r     <= '0;
      vidx_r    <= '0;
      op_r      <= '0;
      k_r       <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_GRID_WIDTH:  gw_r  <= cfg_wdata[GW_W-1:0];
          REG_GRID_HEIGHT: gh_r  <= cfg_wdata[ROW_W-1:0];
          REG_DT_DX:       dtx_r <= cfg_wdata;
          REG_DT_DY:       dty_r <= cfg_wdata;
        endcase
      end
      if (out_vld_r && out_ch.ready && st_r != S_DONE) out_vld_r <= 1'b0;

      unique case (st_r)
        S_IDLE: begin
          if (in_acc) begin
            cur_r      <= {in_ch.energy, in_ch.momentum_y, in_ch.momentum_x, in_ch.density};
            c_q_r      <= col_r;
            r_q_r      <= row_r - 1'b1;
            interior_r <= interior;
            last_r     <= last_now;
            if (col_p1 >= wc) begin
              col_r <= '0;
              row_r <= (row_p1 >= {1'b0, hc}) ? '0 : row_p1[ROW_W-1:0];
            end else begin
              col_r <= col_nx;
            end
            st_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          left_r <= mid_c_q;
          lft_r  <= left_r;
          ctr_r  <= mid_c_q;
          rgt_r  <= mid_r_q;
          bot_r  <= low_c_q;
          vidx_r <= '0;
          st_r   <= interior_r ? S_DIV_GO : S_IDLE;
        end
        S_DIV_GO: st_r <= S_DIV;
        S_DIV: begin
          if (div_rsp.done) begin
            vel_r[vidx_r] <= div_rsp.quot;
            if (vidx_r == VI_W'(NVEL - 1)) begin
              st_r <= S_FACE;
            end else begin
              vidx_r <= vidx_r + 1'b1;
              st_r   <= S_DIV_GO;
            end
          end
        end
        S_FACE: begin
          face_r[0] <= half_sum(vel_r[2], vel_r[0]);
          face_r[1] <= half_sum(vel_r[3], vel_r[0]);
          face_r[2] <= half_sum(vel_r[4], vel_r[1]);
          face_r[3] <= half_sum(vel_r[5], vel_r[1]);
          k_r  <= '0;
          op_r <= '0;
          st_r <= S_SEL;
        end
        S_SEL: begin
          a_r   <= sel_a;
          b_r   <= sel_b;
          neg_r <= sel_neg;
          st_r  <= S_MLO;
        end
        S_MLO: begin
          p_r  <= {(WIDE_W-VAL_W)'(0), a_r} * {(WIDE_W-VAL_W)'(0), b_r[VAL_W-1:0]};
          st_r <= S_MHI;
        end
        S_MHI: begin
          acc_r <= PROD_W'(p_r);
          p_r   <= {(WIDE_W-VAL_W)'(0), a_r} *
                   {(WIDE_W-(BX_W-VAL_W))'(0), b_r[BX_W-1:VAL_W]};
          st_r  <= S_ACC;
        end
        S_ACC: begin
          acc_r <= acc_r + {p_r[PROD_W-VAL_W-1:0], VAL_W'(0)};
          st_r  <= S_FIN;
        end
        S_FIN: begin
          prod_r[op_r] <= fin_res;
          if (op_r == OP_W'(3)) begin
            st_r <= S_DIFF;
          end else if (op_r == OP_W'(NOPS - 1)) begin
            st_r <= S_UPD;
          end else begin
            op_r <= op_r + 1'b1;
            st_r <= S_SEL;
          end
        end
        S_DIFF: begin
          dx_r <= prod_r[1] - prod_r[0];
          dy_r <= prod_r[3] - prod_r[2];
          op_r <= OP_W'(4);
          st_r <= S_SEL;
        end
        S_UPD: begin
          nv_r[k_r] <= upd_val;
          op_r      <= '0;
          if (k_r == K_W'(NQ - 1)) begin
            st_r <= S_DONE;
          end else begin
            k_r  <= k_r + 1'b1;
            st_r <= S_SEL;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_vld_r <= 1'b1;
            o_den_r   <= nv_r[0];
            o_mx_r    <= nv_r[1];
            o_my_r    <= nv_r[2];
            o_en_r    <= nv_r[3];
            o_col_r   <= c_q_r;
            o_row_r   <= r_q_r;
            o_last_r  <= last_r;
            st_r      <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // channel outputs
  assign in_ch.ready           = (st_r == S_IDLE);
  assign out_ch.valid          = out_vld_r;
  assign out_ch.new_density    = o_den_r;
  assign out_ch.new_momentum_x = o_mx_r;
  assign out_ch.new_momentum_y = o_my_r;
  assign out_ch.new_energy     = o_en_r;
  assign out_ch.cell_column    = o_col_r;
  assign out_ch.cell_row       = o_row_r;
  assign out_ch.last_cell      = o_last_r;

  // a beat always starts the row shift
  a_beat_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> st_r == S_LOAD)
    else $error("input beat did not start the row shift");

  // a finished cell lands in the output register when it is free
  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DONE) && out_free |=> out_vld_r && (st_r == S_IDLE))
    else $error("finished cell not registered");

  // divider answers only while the sequencer waits on it
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> st_r == S_DIV)
    else $error("divider result with no division pending");

endmodule
